/* design/itra_pkg.sv */
`timescale 1ns / 1ps

package itra_pkg;

    localparam int VALUE_BITS   = 32;
    localparam int RADIX_W      = 8;
    localparam int CHAR_W       = 8;
    localparam int DIGIT_W      = 6;
    localparam int CNT_W        = $clog2(VALUE_BITS + 1);
    localparam int STACK_ADDR_W = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] MIN_BASE   = 8'd2;
    localparam logic [RADIX_W-1:0] MAX_BASE   = 8'd36;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [DIGIT_W-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] quotient;
        logic [DIGIT_W-1:0]    remainder;
    } t_div_res;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_DIGITS) begin
            return CHAR_ZERO + d_ext;
        end else begin
            return CHAR_A + d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_DIGITS};
        end
    endfunction

endpackage

/* design/itra_in_if.sv */
`timescale 1ns / 1ps

interface itra_in_if import itra_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] number_in;
    logic        [RADIX_W-1:0]    radix;

    modport source (output valid, output number_in, output radix, input ready);
    modport sink   (input valid, input number_in, input radix, output ready);
endinterface

/* design/itra_out_if.sv */
`timescale 1ns / 1ps

interface itra_out_if import itra_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              bad_radix;

    modport source (output valid, output char_code, output last_char, output bad_radix,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input bad_radix,
                    output ready);
endinterface

/* design/integer_to_radix_ascii.sv */
`timescale 1ns / 1ps

// Channel | Dir | Payload                               | Beat
// i_in    | in  | number_in[31:0] signed, radix[7:0]    | one value to convert
// o_out   | out | char_code[7:0], last_char, bad_radix  | one character
//
// Each digit costs one pass of the shared 1-bit-per-cycle divider: a load and
// one step per bit; the digit store overlaps the next load. Each digit character
// then takes read, load and hand over, plus any stall; the sign only a hand over.
// A bad base gives its one beat on the cycle after acceptance.
// i_in.ready is high only when idle. Reset is synchronous; no clearing pass.
module integer_to_radix_ascii import itra_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itra_in_if.sink      i_in,
    itra_out_if.source   o_out
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_LD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic               r_bad, n_bad;
    logic [DIGIT_W-1:0] r_base, n_base;

    logic                  in_acc;
    logic                  base_bad;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag;
    logic [CNT_W-1:0]      cnt_dec;
    t_div_req              div_req;
    t_div_res              div_res;
    logic                  wr_en;
    logic                  rd_en;
    logic [DIGIT_W-1:0]    rd_data;

    assign in_acc   = i_in.valid && i_in.ready;
    assign base_bad = (i_in.radix < MIN_BASE) || (i_in.radix > MAX_BASE);
    assign raw      = $unsigned(i_in.number_in);
    assign mag      = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    assign cnt_dec  = r_cnt - 1'b1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_char  = r_char;
        n_last  = r_last;
        n_bad   = r_bad;
        n_base  = r_base;
        div_req = '0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cnt = '0;
                    if (base_bad) begin
                        n_char  = CHAR_NONE;
                        n_last  = 1'b1;
                        n_bad   = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_neg            = raw[VALUE_BITS-1];
                        n_base           = i_in.radix[DIGIT_W-1:0];
                        div_req.start    = 1'b1;
                        div_req.dividend = mag;
                        div_req.divisor  = i_in.radix[DIGIT_W-1:0];
                        n_state          = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    wr_en = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (div_res.quotient != '0) begin
                        // feed the quotient back in with the held base
                        div_req.start    = 1'b1;
                        div_req.dividend = div_res.quotient;
                        div_req.divisor  = r_base;
                    end else if (r_neg) begin
                        n_char  = CHAR_MINUS;
                        n_last  = 1'b0;
                        n_bad   = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_cnt   = cnt_dec;
                n_state = S_LD;
            end
            S_LD: begin
                n_char  = digit_char(rd_data);
                n_last  = (r_cnt == '0);
                n_bad   = 1'b0;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = (r_cnt == '0) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_neg   <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        r_bad  <= n_bad;
        r_base <= n_base;
    end

    // the divider loads its divisor on every start, so each start carries the base

    itra_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_res   (div_res)
    );

    itra_stack u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[STACK_ADDR_W-1:0]),
        .i_wr_data (div_res.remainder),
        .i_rd_en   (rd_en),
        .i_rd_addr (cnt_dec[STACK_ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;
    assign o_out.bad_radix = r_bad;

endmodule

/* design/itra_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module itra_div import itra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_res o_res
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_steps;
    logic [VALUE_BITS-1:0] r_q;
    logic [DIGIT_W-1:0]    r_rem;
    logic [DIGIT_W-1:0]    r_divisor;

    logic [DIGIT_W:0]      trial;
    logic                  fits;
    logic [DIGIT_W:0]      diff;

    always_comb begin
        trial = {r_rem, r_q[VALUE_BITS-1]};
        fits  = trial >= {1'b0, r_divisor};
        diff  = trial - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_steps <= CNT_W'(VALUE_BITS);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q       <= i_req.dividend;
            r_rem     <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_BITS-2:0], fits};
            r_rem <= fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_q;
    assign o_res.remainder = r_rem;

endmodule

/* design/itra_stack.sv */
`timescale 1ns / 1ps

// Digit store: digits arrive least significant first and leave in reverse.
module itra_stack import itra_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [STACK_ADDR_W-1:0] i_wr_addr,
    input  logic [DIGIT_W-1:0]      i_wr_data,
    input  logic                    i_rd_en,
    input  logic [STACK_ADDR_W-1:0] i_rd_addr,
    output logic [DIGIT_W-1:0]      o_rd_data
);

    logic [DIGIT_W-1:0] r_mem [VALUE_BITS];
    logic [DIGIT_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/itra_chk.sv */
`timescale 1ns / 1ps

module itra_chk import itra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [RADIX_W-1:0] i_radix,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    input  logic              i_bad_radix
);

    // held beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_char_code) && $stable(i_last_char)
            && $stable(i_bad_radix))
        else $error("output beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while a character is pending");

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_radix |-> i_last_char && (i_char_code == CHAR_NONE))
        else $error("error beat malformed");

    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && ((i_radix < MIN_BASE) || (i_radix > MAX_BASE))
            |=> i_out_valid && i_bad_radix)
        else $error("bad base not flagged on next cycle");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_char |=> i_in_ready)
        else $error("not ready after final character");

endmodule

bind integer_to_radix_ascii itra_chk u_itra_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_radix     (i_in.radix),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_char_code (o_out.char_code),
    .i_last_char (o_out.last_char),
    .i_bad_radix (o_out.bad_radix)
);
